// ----- src/lfr_pkg.sv -----
`default_nettype none

package lfr_pkg;

    // sizes of the request fields and the byte counter
    localparam int COORD_W    = 16;
    localparam int BR_W       = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // chunk sizing for continue items
    localparam int CHUNK_BYTES  = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int CHUNK_EFF    = (CHUNK_BYTES > MAX_RESULTS) ? MAX_RESULTS :
                                  ((CHUNK_BYTES < 1) ? 1 : CHUNK_BYTES);
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    // default panel side limit
    localparam int MAX_SIDE_DEF = 320;

    // saturation value of the pixel byte count (largest even 18-bit value)
    localparam logic [BR_W-1:0] CNT_SAT = 18'h3FFFE;

    // controller commands
    localparam logic [7:0] CMD_COL = 8'h2A;
    localparam logic [7:0] CMD_ROW = 8'h2B;
    localparam logic [7:0] CMD_MEM = 8'h2C;

    // window sequence: column command, four bytes, row command, four bytes, memory write
    localparam logic [CNT_W-1:0] WIN_LAST = CNT_W'(10);

    // result kinds
    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    // job kinds between front and back
    localparam logic [1:0] JOB_WINDOW = 2'd0;
    localparam logic [1:0] JOB_PIXELS = 2'd1;
    localparam logic [1:0] JOB_REJECT = 2'd2;
    localparam logic [1:0] JOB_IDLE   = 2'd3;

    // input commands
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_CONTINUE = 1'b1;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SHIFT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SHIFT      = 3'd4;

    // job queue depth
    localparam int JOB_DEPTH = 4;

    typedef struct packed {
        logic [8:0] panel_width;
        logic [8:0] panel_height;
        logic [1:0] rotation;
        logic [7:0] x_shift;
        logic [7:0] y_shift;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] col_start;
        logic [COORD_W-1:0] col_end;
        logic [COORD_W-1:0] row_start;
        logic [COORD_W-1:0] row_end;
        logic [COORD_W-1:0] color;
        logic [CNT_W-1:0]   count;
        logic               phase;
        logic               done;
    } job_t;

endpackage

`default_nettype wire

// ----- src/lfr_front.sv -----
`default_nettype none

module lfr_front #(
    parameter int MAX_SIDE = lfr_pkg::MAX_SIDE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lfr_pkg::cfg_t             cfg,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      in_command,
    input  wire logic [lfr_pkg::COORD_W-1:0] in_x_start,
    input  wire logic [lfr_pkg::COORD_W-1:0] in_y_start,
    input  wire logic [lfr_pkg::COORD_W-1:0] in_x_end,
    input  wire logic [lfr_pkg::COORD_W-1:0] in_y_end,
    input  wire logic [lfr_pkg::COORD_W-1:0] in_fill_rgb565,
    output logic                           job_valid,
    input  wire logic                      job_ready,
    output lfr_pkg::job_t                  job
);
    import lfr_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int PROD_W = 2 * SIDE_W;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_cmd_reg;
    logic                s1_reject_reg;
    logic [SIDE_W-1:0]   s1_xs_reg, s1_xe_reg, s1_ys_reg, s1_ye_reg;
    logic [SIDE_W-1:0]   s1_wlen_reg, s1_hlen_reg;
    logic [COORD_W-1:0]  s1_color_reg;

    logic [BR_W-1:0]     br_reg, br_next;
    logic [COORD_W-1:0]  color_reg, color_next;

    logic                accept, push;
    logic [COORD_W-1:0]  eff_w, eff_h, max16;
    logic [COORD_W-1:0]  xs_o, xe_o, ys_o, ye_o, xe_c, ye_c;
    logic                reject;

    logic [PROD_W-1:0]   prod;
    logic [BR_W-1:0]     total;
    logic [COORD_W-1:0]  wm1, hm1, xs16, xe16, ys16, ye16;
    logic [COORD_W-1:0]  cs, ce, rs, re;
    logic [CNT_W-1:0]    chunk;
    logic [BR_W-1:0]     br_after;
    job_t                job_next;

    // effective panel size, clipped to the side limit
    assign max16 = COORD_W'(MAX_SIDE);
    assign eff_w = (COORD_W'(cfg.panel_width) > max16) ? max16 : COORD_W'(cfg.panel_width);
    assign eff_h = (COORD_W'(cfg.panel_height) > max16) ? max16 : COORD_W'(cfg.panel_height);

    // first stage: order corners, reject check, clamp, side lengths
    always_comb
    begin
        xs_o   = (in_x_end < in_x_start) ? in_x_end : in_x_start;
        xe_o   = (in_x_end < in_x_start) ? in_x_start : in_x_end;
        ys_o   = (in_y_end < in_y_start) ? in_y_end : in_y_start;
        ye_o   = (in_y_end < in_y_start) ? in_y_start : in_y_end;
        reject = (xs_o >= eff_w) || (ys_o >= eff_h);
        xe_c   = (xe_o >= eff_w) ? (eff_w - COORD_W'(1)) : xe_o;
        ye_c   = (ye_o >= eff_h) ? (eff_h - COORD_W'(1)) : ye_o;
    end

    assign push          = s1_valid_reg && job_ready;
    assign in_ready      = !s1_valid_reg || job_ready;
    assign accept        = in_valid && in_ready;
    assign s1_valid_next = accept ? 1'b1 : (push ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= in_command;
            s1_reject_reg <= reject;
            s1_xs_reg     <= SIDE_W'(xs_o);
            s1_xe_reg     <= SIDE_W'(xe_c);
            s1_ys_reg     <= SIDE_W'(ys_o);
            s1_ye_reg     <= SIDE_W'(ye_c);
            s1_wlen_reg   <= SIDE_W'(xe_c - xs_o + COORD_W'(1));
            s1_hlen_reg   <= SIDE_W'(ye_c - ys_o + COORD_W'(1));
            s1_color_reg  <= in_fill_rgb565;
        end
    end

    // second stage: byte count, window mapping, chunk bookkeeping
    assign prod  = PROD_W'(s1_wlen_reg) * PROD_W'(s1_hlen_reg);
    assign total = (32'(prod) > 32'(CNT_SAT >> 1)) ? CNT_SAT : BR_W'({32'(prod), 1'b0});

    assign wm1  = eff_w - COORD_W'(1);
    assign hm1  = eff_h - COORD_W'(1);
    assign xs16 = COORD_W'(s1_xs_reg);
    assign xe16 = COORD_W'(s1_xe_reg);
    assign ys16 = COORD_W'(s1_ys_reg);
    assign ye16 = COORD_W'(s1_ye_reg);

    always_comb
    begin
        unique case (cfg.rotation)
            ROT_90:
            begin
                cs = ys16;        ce = ye16;
                rs = wm1 - xe16;  re = wm1 - xs16;
            end
            ROT_180:
            begin
                cs = wm1 - xe16;  ce = wm1 - xs16;
                rs = hm1 - ye16;  re = hm1 - ys16;
            end
            ROT_270:
            begin
                cs = hm1 - ye16;  ce = hm1 - ys16;
                rs = xs16;        re = xe16;
            end
            default:
            begin
                cs = xs16;        ce = xe16;
                rs = ys16;        re = ye16;
            end
        endcase
    end

    assign chunk    = (br_reg < BR_W'(CHUNK_EFF)) ? CNT_W'(br_reg) : CNT_W'(CHUNK_EFF);
    assign br_after = br_reg - BR_W'(chunk);

    always_comb
    begin
        job_next   = '0;
        br_next    = br_reg;
        color_next = color_reg;
        if (s1_cmd_reg == CMD_START)
        begin
            if (s1_reject_reg)
            begin
                job_next.kind = JOB_REJECT;
                br_next       = '0;
            end
            else
            begin
                job_next.kind      = JOB_WINDOW;
                job_next.col_start = cs + COORD_W'(cfg.x_shift);
                job_next.col_end   = ce + COORD_W'(cfg.x_shift);
                job_next.row_start = rs + COORD_W'(cfg.y_shift);
                job_next.row_end   = re + COORD_W'(cfg.y_shift);
                br_next            = total;
                color_next         = s1_color_reg;
            end
        end
        else if (br_reg == '0)
        begin
            job_next.kind = JOB_IDLE;
        end
        else
        begin
            job_next.kind  = JOB_PIXELS;
            job_next.color = color_reg;
            job_next.count = chunk;
            job_next.phase = br_reg[0];
            job_next.done  = (br_after == '0);
            br_next        = br_after;
        end
    end

    assign job_valid = s1_valid_reg;
    assign job       = job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            br_reg       <= '0;
            color_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (push)
            begin
                br_reg    <= br_next;
                color_reg <= color_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/lfr_fifo.sv -----
`default_nettype none

module lfr_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire lfr_pkg::job_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output lfr_pkg::job_t      rd_data
);
    import lfr_pkg::*;

    localparam int PTR_W = $clog2(JOB_DEPTH);

    job_t              mem [JOB_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != (PTR_W + 1)'(JOB_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // pointers wrap at the queue depth
    assign wr_ptr_next = do_wr ? ((wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + PTR_W'(1))
                               : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? ((rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + PTR_W'(1))
                               : rd_ptr_reg;
    assign count_next  = count_reg + (PTR_W + 1)'(do_wr) - (PTR_W + 1)'(do_rd);

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/lfr_back.sv -----
`default_nettype none

module lfr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire lfr_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output logic               out_fill_done
);
    import lfr_pkg::*;

    logic              cur_valid_reg, cur_valid_next;
    job_t              cur_job_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_kind_reg;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg;
    logic              m_done_reg;

    logic [1:0]        res_kind;
    logic [7:0]        res_byte;
    logic              res_last;
    logic              res_done;
    logic              emit, pop;

    // result for the current position in the current job
    always_comb
    begin
        res_kind = KIND_DATA;
        res_byte = '0;
        res_last = 1'b0;
        res_done = 1'b0;
        unique case (cur_job_reg.kind)
            JOB_WINDOW:
            begin
                res_last = (idx_reg == WIN_LAST);
                unique case (idx_reg)
                    CNT_W'(0):  begin res_kind = KIND_CMD; res_byte = CMD_COL; end
                    CNT_W'(1):  res_byte = cur_job_reg.col_start[15:8];
                    CNT_W'(2):  res_byte = cur_job_reg.col_start[7:0];
                    CNT_W'(3):  res_byte = cur_job_reg.col_end[15:8];
                    CNT_W'(4):  res_byte = cur_job_reg.col_end[7:0];
                    CNT_W'(5):  begin res_kind = KIND_CMD; res_byte = CMD_ROW; end
                    CNT_W'(6):  res_byte = cur_job_reg.row_start[15:8];
                    CNT_W'(7):  res_byte = cur_job_reg.row_start[7:0];
                    CNT_W'(8):  res_byte = cur_job_reg.row_end[15:8];
                    CNT_W'(9):  res_byte = cur_job_reg.row_end[7:0];
                    CNT_W'(10): begin res_kind = KIND_CMD; res_byte = CMD_MEM; end
                    default:    res_byte = '0;
                endcase
            end
            JOB_PIXELS:
            begin
                // even remaining count sends the high byte
                res_byte = (cur_job_reg.phase ^ idx_reg[0]) ? cur_job_reg.color[7:0]
                                                            : cur_job_reg.color[15:8];
                res_last = (idx_reg == cur_job_reg.count - CNT_W'(1));
                res_done = res_last && cur_job_reg.done;
            end
            JOB_REJECT:
            begin
                res_kind = KIND_REJECT;
                res_last = 1'b1;
                res_done = 1'b1;
            end
            default:
            begin
                res_kind = KIND_IDLE;
                res_last = 1'b1;
                res_done = 1'b1;
            end
        endcase
    end

    assign emit      = cur_valid_reg && (!m_valid_reg || out_ready);
    assign pop       = job_valid && (!cur_valid_reg || (emit && res_last));
    assign job_ready = pop;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (emit && res_last)
        begin
            cur_valid_next = 1'b0;
            idx_next       = '0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    assign m_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_job_reg <= job;
        end
        if (emit)
        begin
            m_kind_reg <= res_kind;
            m_byte_reg <= res_byte;
            m_last_reg <= res_last;
            m_done_reg <= res_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_kind      = m_kind_reg;
    assign out_byte      = m_byte_reg;
    assign out_last      = m_last_reg;
    assign out_fill_done = m_done_reg;

endmodule

`default_nettype wire

// ----- src/lcd_fill_rect_command_stream_core.sv -----
`default_nettype none

// Fill-rectangle command generator for an SPI display controller. A start
// item (tuser = 0) carries two corners and an RGB565 colour; the corners are
// put in order, the request is rejected with a single kind-2 transfer when the
// start lies off the panel, otherwise the end is clamped, the window is mapped
// through the rotation and shifts, and eleven transfers go out: column set
// 0x2A, four address bytes, row set 0x2B, four address bytes, memory write
// 0x2C. Each continue item (tuser = 1) sends the next chunk of up to 32 colour
// bytes, high byte first, or a single kind-3 transfer when nothing is pending.
// Results leave at one byte per clock from the back sequencer while the
// receiver is ready; an item has 1, 11 or up to the chunk size (32 by
// default) results. The front stage accepts one item per clock and files
// each into a four-entry job queue; it stalls only when that queue is full.
// The first output byte passes the front stage register, the job queue,
// the current-job register and the output register before it is offered.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
module lcd_fill_rect_command_stream_core #(
    parameter int MAX_SIDE = lfr_pkg::MAX_SIDE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [lfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48], fill_rgb565[79:64]
    input  wire logic [79:0]                      s_tdata,
    // command[0]
    input  wire logic                             s_tuser,
    // byte stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0], fill_done[8], zero[15:9]
    output logic [15:0]                           m_tdata,
    // kind[1:0]
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast
);
    import lfr_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_wr_valid, q_wr_ready;
    job_t  q_wr_data;
    logic  q_rd_valid, q_rd_ready;
    job_t  q_rd_data;
    logic  out_fill_done;
    logic [7:0] out_byte;

    // register file; writes to unused indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:  cfg_next.panel_width  = cfg_data[8:0];
                REG_PANEL_HEIGHT: cfg_next.panel_height = cfg_data[8:0];
                REG_ROTATION:     cfg_next.rotation     = cfg_data[1:0];
                REG_X_SHIFT:      cfg_next.x_shift      = cfg_data[7:0];
                REG_Y_SHIFT:      cfg_next.y_shift      = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width  <= 9'd240;
            cfg_reg.panel_height <= 9'd240;
            cfg_reg.rotation     <= ROT_0;
            cfg_reg.x_shift      <= '0;
            cfg_reg.y_shift      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: ordering, clipping, mapping and byte bookkeeping
    lfr_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_command     (s_tuser),
        .in_x_start     (s_tdata[15:0]),
        .in_y_start     (s_tdata[31:16]),
        .in_x_end       (s_tdata[47:32]),
        .in_y_end       (s_tdata[63:48]),
        .in_fill_rgb565 (s_tdata[79:64]),
        .job_valid      (q_wr_valid),
        .job_ready      (q_wr_ready),
        .job            (q_wr_data)
    );

    // job queue decouples intake from byte output
    lfr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // back: one byte per transfer from the current job
    lfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_rd_valid),
        .job_ready     (q_rd_ready),
        .job           (q_rd_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (m_tuser),
        .out_byte      (out_byte),
        .out_last      (m_tlast),
        .out_fill_done (out_fill_done)
    );

    assign m_tdata = {7'b0, out_fill_done, out_byte};

endmodule

`default_nettype wire

// ----- src/lfr_checker.sv -----
`default_nettype none

module lfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import lfr_pkg::*;

    // a stalled transfer stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer dropped while stalled");

    // command bytes are only the three controller commands
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_CMD) |->
            (m_tdata[7:0] == CMD_COL || m_tdata[7:0] == CMD_ROW ||
             m_tdata[7:0] == CMD_MEM) && !m_tdata[8])
        else $error("bad command byte");

    // reject and idle are single transfers that close the item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REJECT || m_tuser == KIND_IDLE) |->
            m_tlast && m_tdata[8] && (m_tdata[7:0] == 8'h00))
        else $error("reject or idle result malformed");

    // fill done only on the closing transfer of an item
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tlast)
        else $error("fill done without last");

endmodule

bind lcd_fill_rect_command_stream_core lfr_checker u_lfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
    import lfr_pkg::*;

    // one byte-stream transfer as seen on the master side
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       done;
    } beat_t;

    // one row of the directed table; typed rows carry their single expected transfer
    typedef struct packed {
        logic        cmd;
        logic [15:0] xs;
        logic [15:0] ys;
        logic [15:0] xe;
        logic [15:0] ye;
        logic [15:0] color;
        logic        typed;
        logic [1:0]  typed_kind;
    } stim_row_t;

    localparam int N_DIRECTED = 19;
    localparam int N_PHASES   = 7;
    localparam int DRAIN_CYCLES = 8;

    // directed requests at the reset setting (240 x 240, no rotation, no shift)
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // nothing pending right after reset
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_IDLE},
        // single pixel at the origin, white
        '{CMD_START,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_IDLE},
        // both corner pairs given in reverse order
        '{CMD_START,    16'd10,   16'd7,    16'd3,    16'd2,    16'hA55A, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        // start during a fill, off the panel in x: rejected and pending bytes dropped
        '{CMD_START,    16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0F0F, 1'b1, KIND_REJECT},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_IDLE},
        // off the panel in y
        '{CMD_START,    16'd0,    16'd240,  16'd5,    16'd300,  16'h00FF, 1'b1, KIND_REJECT},
        // end clamped to the panel edge
        '{CMD_START,    16'd230,  16'd235,  16'hFFFF, 16'hFFFF, 16'h1234, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_IDLE},
        // whole panel, then abandoned by the next start
        '{CMD_START,    16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, KIND_CMD},
        // bottom right pixel
        '{CMD_START,    16'd239,  16'd239,  16'd239,  16'd239,  16'h5AA5, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, KIND_CMD},
        '{CMD_CONTINUE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, KIND_IDLE}
    };

    // random requests per register setting, after the directed part
    localparam int PHASE_ITEMS [N_PHASES] = '{32, 12, 6, 32, 6, 28, 28};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // mirror of the block's registers and fill state
    cfg_t          panel_cfg;
    logic [BR_W-1:0] pixel_bytes_left;
    logic [15:0]   fill_color;

    // transfers still owed by the block, oldest first
    beat_t byte_stream_due [$];

    int  mismatches = 0;
    bit  src_calm = 1'b0;

    always #5 clk = ~clk;

    lcd_fill_rect_command_stream_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // panel side as the block sees it, capped at the largest supported side
    function automatic int eff_side(input logic [8:0] side);
        return (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(side);
    endfunction

    // most gaps are zero, some short, a few long; calm stretches have none
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // expected byte stream for one request, updating the mirrored fill state
    function automatic void predict_fill_request(input logic cmd, input logic [79:0] req,
                                                 output beat_t beats [$]);
        int xs, ys, xe, ye, w, h, t, total, chunk;
        int cs, ce, rs, re;
        logic [15:0] ca, cb, ra, rb;
        logic [7:0] pix;
        beats = {};
        if (cmd == CMD_START) begin
            xs = int'(req[15:0]);
            ys = int'(req[31:16]);
            xe = int'(req[47:32]);
            ye = int'(req[63:48]);
            w  = eff_side(panel_cfg.panel_width);
            h  = eff_side(panel_cfg.panel_height);
            if (xe < xs) begin t = xs; xs = xe; xe = t; end
            if (ye < ys) begin t = ys; ys = ye; ye = t; end
            if (xs >= w || ys >= h) begin
                // rejected: pending bytes dropped, colour kept
                pixel_bytes_left = '0;
                beats.push_back('{KIND_REJECT, 8'h00, 1'b1, 1'b1});
                return;
            end
            if (xe >= w) xe = w - 1;
            if (ye >= h) ye = h - 1;
            total = (xe - xs + 1) * (ye - ys + 1) * 2;
            if (total > int'(CNT_SAT)) total = int'(CNT_SAT);
            pixel_bytes_left = total[BR_W-1:0];
            fill_color = req[79:64];
            case (panel_cfg.rotation)
                ROT_90:  begin cs = ys; ce = ye; rs = w - 1 - xe; re = w - 1 - xs; end
                ROT_180: begin
                    cs = w - 1 - xe; ce = w - 1 - xs; rs = h - 1 - ye; re = h - 1 - ys;
                end
                ROT_270: begin cs = h - 1 - ye; ce = h - 1 - ys; rs = xs; re = xe; end
                default: begin cs = xs; ce = xe; rs = ys; re = ye; end
            endcase
            // controller addresses wrap at 16 bits
            ca = 16'(cs + panel_cfg.x_shift);
            cb = 16'(ce + panel_cfg.x_shift);
            ra = 16'(rs + panel_cfg.y_shift);
            rb = 16'(re + panel_cfg.y_shift);
            beats.push_back('{KIND_CMD,  CMD_COL,   1'b0, 1'b0});
            beats.push_back('{KIND_DATA, ca[15:8],  1'b0, 1'b0});
            beats.push_back('{KIND_DATA, ca[7:0],   1'b0, 1'b0});
            beats.push_back('{KIND_DATA, cb[15:8],  1'b0, 1'b0});
            beats.push_back('{KIND_DATA, cb[7:0],   1'b0, 1'b0});
            beats.push_back('{KIND_CMD,  CMD_ROW,   1'b0, 1'b0});
            beats.push_back('{KIND_DATA, ra[15:8],  1'b0, 1'b0});
            beats.push_back('{KIND_DATA, ra[7:0],   1'b0, 1'b0});
            beats.push_back('{KIND_DATA, rb[15:8],  1'b0, 1'b0});
            beats.push_back('{KIND_DATA, rb[7:0],   1'b0, 1'b0});
            beats.push_back('{KIND_CMD,  CMD_MEM,   1'b1, 1'b0});
            return;
        end
        if (pixel_bytes_left == '0) begin
            beats.push_back('{KIND_IDLE, 8'h00, 1'b1, 1'b1});
            return;
        end
        chunk = CHUNK_EFF;
        if (chunk > int'(pixel_bytes_left)) chunk = int'(pixel_bytes_left);
        while (chunk > 0) begin
            // an even count left means the high byte is next
            pix = pixel_bytes_left[0] ? fill_color[7:0] : fill_color[15:8];
            pixel_bytes_left = pixel_bytes_left - BR_W'(1);
            chunk--;
            beats.push_back('{KIND_DATA, pix, chunk == 0,
                              (chunk == 0) && (pixel_bytes_left == '0)});
        end
    endfunction

    // one request transfer; the prediction is made at the accepting edge
    task automatic send_request(input logic cmd, input logic [79:0] req,
                                input logic typed, input logic [1:0] typed_kind);
        int gap;
        beat_t beats [$];
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        predict_fill_request(cmd, req, beats);
        if (typed)
            byte_stream_due.push_back('{typed_kind, 8'h00, 1'b1, 1'b1});
        else
            foreach (beats[i])
                byte_stream_due.push_back(beats[i]);
    endtask

    task automatic send_continue();
        logic [79:0] noise;
        noise = {$urandom, $urandom, $urandom};
        send_request(CMD_CONTINUE, noise, 1'b0, KIND_CMD);
    endtask

    // corners for a random start: mostly small windows on the panel, some off it,
    // some wild, a quarter of each axis given in reverse order
    function automatic logic [79:0] random_corners();
        int w, h, xs, ys, xe, ye, r, t, reach;
        logic [15:0] color;
        w = eff_side(panel_cfg.panel_width);
        h = eff_side(panel_cfg.panel_height);
        r = $urandom_range(0, 99);
        color = 16'($urandom);
        if (r < 12 || w == 0 || h == 0) begin
            xs = $urandom_range(0, 65535);
            ys = $urandom_range(0, 65535);
            xe = $urandom_range(0, 65535);
            ye = $urandom_range(0, 65535);
        end else if (r < 22) begin
            xs = $urandom_range(0, w - 1);
            ys = $urandom_range(0, h - 1);
            if ($urandom_range(0, 1))
                xs = w + $urandom_range(0, 40);
            else
                ys = h + $urandom_range(0, 40);
            xe = xs + $urandom_range(0, 8);
            ye = ys + $urandom_range(0, 8);
        end else begin
            reach = (r >= 88) ? 30 : 5;
            xs = $urandom_range(0, w - 1);
            ys = $urandom_range(0, h - 1);
            xe = xs + $urandom_range(0, reach);
            ye = ys + $urandom_range(0, reach);
        end
        if ($urandom_range(0, 3) == 0) begin t = xs; xs = xe; xe = t; end
        if ($urandom_range(0, 3) == 0) begin t = ys; ys = ye; ye = t; end
        return {color, ye[15:0], xe[15:0], ys[15:0], xs[15:0]};
    endfunction

    // start followed by its pixel chunks, sometimes cut short or overrun
    task automatic run_random_requests(input int quota);
        int sent, cap, n;
        sent = 0;
        while (sent < quota) begin
            src_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 8) begin
                send_continue();
                sent++;
            end
            send_request(CMD_START, random_corners(), 1'b0, KIND_CMD);
            sent++;
            cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 12;
            n = 0;
            while (pixel_bytes_left != '0 && n < cap) begin
                send_continue();
                n++;
                sent++;
            end
            if ($urandom_range(0, 99) < 30) begin
                send_continue();
                sent++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // wait for the stream to run dry, then for the pipeline to settle
    task automatic drain_stream();
        while (byte_stream_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            REG_PANEL_WIDTH:  panel_cfg.panel_width  = value[8:0];
            REG_PANEL_HEIGHT: panel_cfg.panel_height = value[8:0];
            REG_ROTATION:     panel_cfg.rotation     = value[1:0];
            REG_X_SHIFT:      panel_cfg.x_shift      = value[7:0];
            REG_Y_SHIFT:      panel_cfg.y_shift      = value[7:0];
            default: ;
        endcase
    endtask

    // register settings per phase: size extremes, every rotation, non-square panels
    task automatic apply_phase(input int p);
        int w, h;
        case (p)
            0: begin w = 320; h = 150; write_reg(REG_ROTATION, ROT_90); end
            1: begin w = 1;   h = 320; write_reg(REG_ROTATION, ROT_180); end
            2: begin w = 0;   h = 1;   write_reg(REG_ROTATION, ROT_270); end
            3: begin w = 511; h = 200; write_reg(REG_ROTATION, ROT_270); end
            4: begin w = 137; h = 0;   write_reg(REG_ROTATION, ROT_0); end
            5: begin w = 137; h = 53;  write_reg(REG_ROTATION, ROT_180); end
            default: begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 320);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 320);
                write_reg(REG_ROTATION, $urandom_range(0, 3));
            end
        endcase
        write_reg(REG_PANEL_WIDTH, w);
        write_reg(REG_PANEL_HEIGHT, h);
        case (p)
            0:       begin write_reg(REG_X_SHIFT, 255); write_reg(REG_Y_SHIFT, 255); end
            1:       begin write_reg(REG_X_SHIFT, 0);   write_reg(REG_Y_SHIFT, 255); end
            2:       begin write_reg(REG_X_SHIFT, 255); write_reg(REG_Y_SHIFT, 0); end
            3:       begin write_reg(REG_X_SHIFT, 17);  write_reg(REG_Y_SHIFT, 3); end
            4:       begin write_reg(REG_X_SHIFT, 0);   write_reg(REG_Y_SHIFT, 0); end
            default: begin
                write_reg(REG_X_SHIFT, $urandom_range(0, 255));
                write_reg(REG_Y_SHIFT, $urandom_range(0, 255));
            end
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // output checker: every accepted transfer against the oldest expectation
    always @(posedge clk) begin
        beat_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (byte_stream_due.size() == 0) begin
                report_mismatch("unexpected transfer, byte", m_tdata[7:0], 0);
            end else begin
                want = byte_stream_due.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", m_tdata[7:0], want.data);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
                if (m_tdata[8] !== want.done)
                    report_mismatch("fill_done", m_tdata[8], want.done);
            end
        end
    end

    // receiver: ready in bursts, dropped for random gaps, sometimes held high for a while
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat (60) @(posedge clk);
            else
                repeat ($urandom_range(1, 40)) @(posedge clk);
            gap = pick_gap(1'b0);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // main sequence: reset, directed table, then random phases at several settings
    initial begin
        panel_cfg.panel_width  = 9'd240;
        panel_cfg.panel_height = 9'd240;
        panel_cfg.rotation     = ROT_0;
        panel_cfg.x_shift      = 8'd0;
        panel_cfg.y_shift      = 8'd0;
        pixel_bytes_left       = '0;
        fill_color             = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED_ROWS[i].cmd,
                         {DIRECTED_ROWS[i].color, DIRECTED_ROWS[i].ye, DIRECTED_ROWS[i].xe,
                          DIRECTED_ROWS[i].ys, DIRECTED_ROWS[i].xs},
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_kind);
        s_tvalid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            drain_stream();
            apply_phase(p);
            run_random_requests(PHASE_ITEMS[p]);
        end

        drain_stream();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/lfr_pkg.sv
src/lfr_front.sv
src/lfr_fifo.sv
src/lfr_back.sv
src/lcd_fill_rect_command_stream_core.sv
src/lfr_checker.sv
tb/testbench.sv
